>>> rtl/yuv420_alpha_overlay_assert.svh
// ----------------------------------------------------------------------------
// yuv420 alpha overlay assertion macros
// concurrent assertion helpers, clocked on clk, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef YUV420_ALPHA_OVERLAY_ASSERT_SVH
`define YUV420_ALPHA_OVERLAY_ASSERT_SVH

`ifndef SYNTH
// property checked on every clk edge, off while reset is low
`define YUVOVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked on every clk edge, also during reset
`define YUVOVL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define YUVOVL_ASSERT(lbl, prop, msg)
`define YUVOVL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/yuvovl_pkg.sv
// ----------------------------------------------------------------------------
// yuvovl_pkg
// shared types, register indexes and sizing helpers of the yuv420 overlay
// ----------------------------------------------------------------------------
package yuvovl_pkg;

  // field and register widths
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 13;
  localparam int SIZE_W    = CFG_W + 1;
  localparam int CFG_IDX_W = 2;

  // default geometry limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_ENABLE = 2'd2;

  // chroma pair, u in the low byte
  typedef struct packed {
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] u;
  } chroma_t;

  // position flags of one request
  typedef struct packed {
    logic odd_row;
    logic odd_col;
    logic frame_done;
  } pos_t;

  // clamp a size to 2..limit and force it even
  function automatic logic [SIZE_W-1:0] fit_size(input logic [CFG_W-1:0] v,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] m;
    logic [SIZE_W-1:0] t;
    m = lim & ~SIZE_W'(1);
    if (m < SIZE_W'(2)) m = SIZE_W'(2);
    t = {1'b0, v};
    if (t < SIZE_W'(2)) t = SIZE_W'(2);
    if (t > m) t = m;
    return t & ~SIZE_W'(1);
  endfunction

endpackage

>>> rtl/yuvovl_ctrl.sv
// ----------------------------------------------------------------------------
// yuvovl_ctrl
// configuration registers, fitted geometry and raster position counters
// ----------------------------------------------------------------------------
module yuvovl_ctrl import yuvovl_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int COL_W      = $clog2(MAX_WIDTH),
  parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_fire,
  output pos_t                 pos,
  output logic [COL_W-2:0]     slot,
  output logic                 overlay_en
);

  localparam logic [SIZE_W-1:0] W_LIM = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] H_LIM = SIZE_W'(MAX_HEIGHT);

  logic [SIZE_W-1:0] w_fit_r;
  logic [SIZE_W-1:0] h_fit_r;
  logic              enable_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              last_col;
  logic              last_row;

  // configuration writes, sizes kept already fitted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_fit_r  <= fit_size(RST_FRAME_WIDTH, W_LIM);
      h_fit_r  <= fit_size(RST_FRAME_HEIGHT, H_LIM);
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:    w_fit_r  <= fit_size(cfg_wdata, W_LIM);
        REG_FRAME_HEIGHT:   h_fit_r  <= fit_size(cfg_wdata, H_LIM);
        REG_OVERLAY_ENABLE: enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // end of line and end of frame, counters past the end wrap too
  assign last_col = (SIZE_W'(col_r) + SIZE_W'(1)) >= w_fit_r;
  assign last_row = (SIZE_W'(row_r) + SIZE_W'(1)) >= h_fit_r;

  // next raster position
  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end
  end

  // position of the request being accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.odd_row    = row_r[0];
  assign pos.odd_col    = col_r[0];
  assign pos.frame_done = last_col && last_row;
  assign slot           = col_r[COL_W-1:1];
  assign overlay_en     = enable_r;

endmodule

>>> rtl/yuvovl_line_store.sv
// ----------------------------------------------------------------------------
// yuvovl_line_store
// half-line chroma memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module yuvovl_line_store import yuvovl_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF / 2,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  chroma_t       wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output chroma_t       rdata
);

  chroma_t mem [DEPTH];
  chroma_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, a write to the same entry in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (re) rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/yuvovl_blend.sv
// ----------------------------------------------------------------------------
// yuvovl_blend
// alpha blend of luma toward red and of the chroma pair toward mid gray
// ----------------------------------------------------------------------------
module yuvovl_blend import yuvovl_pkg::*; (
  input  logic [PIX_W-1:0] luma_in,
  input  logic [PIX_W-1:0] red_in,
  input  logic [PIX_W-1:0] alpha_in,
  input  chroma_t          chroma_in,
  output logic [PIX_W-1:0] luma_out,
  output chroma_t          chroma_out
);

  localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;

  // floor(((255-a)*b + a*t)/255), divide by 255 as (x + (x>>8) + 1) >> 8
  function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] b,
                                           input logic [PIX_W-1:0] t,
                                           input logic [PIX_W-1:0] a);
    logic [15:0] x;
    logic [16:0] s;
    x = 16'(8'(8'hFF - a)) * 16'(b) + 16'(a) * 16'(t);
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  // zero alpha returns the base value exactly
  assign luma_out     = mix(luma_in, red_in, alpha_in);
  assign chroma_out.u = mix(chroma_in.u, CHROMA_MID, alpha_in);
  assign chroma_out.v = mix(chroma_in.v, CHROMA_MID, alpha_in);

endmodule

>>> rtl/yuv420_alpha_overlay.sv
// ----------------------------------------------------------------------------
// yuv420_alpha_overlay
// watermark blend into an i420 pixel stream, without back-pressure one pixel per clock
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata: luma, u, v, red, alpha
//  out_    | out | out_tvalid/tready  | tdata: luma, u, v; tuser final; tlast done
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
//  one pixel accepted per clock while out_tready is high, out_tvalid rises once the
//  pixel has moved from stage 1 into the result register
//  stage 1 holds the pixel and the registered line store read, the blend sits between
//  stage 1 and the result register, running chroma loops there
//  out_tready low holds the result, stage 1 keeps one more pixel, then stalls
//  reset is synchronous, active low; the line store is not cleared
module yuv420_alpha_overlay import yuvovl_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // luma_in, chroma_u_in, chroma_v_in, mark_red, mark_alpha
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // luma_out, chroma_u_out, chroma_v_out
  output logic                 out_tuser,  // chroma_final
  output logic                 out_tlast   // frame_done
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = COL_W - 1;

  logic             in_fire;
  logic             s1_go;
  pos_t             pos;
  logic [AW-1:0]    slot;
  logic             overlay_en;

  logic             s1_v_r;
  logic [PIX_W-1:0] s1_luma_r;
  chroma_t          s1_chroma_r;
  logic [PIX_W-1:0] s1_red_r;
  logic [PIX_W-1:0] s1_alpha_r;
  pos_t             s1_pos_r;
  logic [AW-1:0]    s1_slot_r;

  chroma_t          run_r;
  chroma_t          store_rd;
  chroma_t          chroma_base;
  chroma_t          chroma_blend;
  logic [PIX_W-1:0] luma_blend;
  logic             store_we;

  logic             out_v_r;
  logic [PIX_W-1:0] out_luma_r;
  chroma_t          out_chroma_r;
  logic             out_final_r;
  logic             out_done_r;

  // handshakes
  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  // configuration and raster position
  yuvovl_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_fire    (in_fire),
    .pos        (pos),
    .slot       (slot),
    .overlay_en (overlay_en)
  );

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  // stage 1 payload, alpha forced to zero while the overlay is off
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_luma_r     <= in_tdata[7:0];
      s1_chroma_r.u <= in_tdata[15:8];
      s1_chroma_r.v <= in_tdata[23:16];
      s1_red_r      <= in_tdata[31:24];
      s1_alpha_r    <= overlay_en ? in_tdata[39:32] : '0;
      s1_pos_r      <= pos;
      s1_slot_r     <= slot;
    end
  end

  // line store, written at odd columns of even rows, read at accept
  assign store_we = s1_go && s1_pos_r.odd_col && !s1_pos_r.odd_row;

  yuvovl_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_slot_r),
    .wdata (chroma_blend),
    .re    (in_fire),
    .raddr (slot),
    .rdata (store_rd)
  );

  // block chroma before this pixel's blend
  always_comb begin
    priority if (s1_pos_r.odd_col) begin
      chroma_base = run_r;
    end else if (s1_pos_r.odd_row) begin
      chroma_base = store_rd;
    end else begin
      chroma_base = s1_chroma_r;
    end
  end

  yuvovl_blend u_blend (
    .luma_in    (s1_luma_r),
    .red_in     (s1_red_r),
    .alpha_in   (s1_alpha_r),
    .chroma_in  (chroma_base),
    .luma_out   (luma_blend),
    .chroma_out (chroma_blend)
  );

  // running chroma pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (s1_go) begin
      run_r <= chroma_blend;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_luma_r   <= luma_blend;
      out_chroma_r <= chroma_blend;
      out_final_r  <= s1_pos_r.odd_row && s1_pos_r.odd_col;
      out_done_r   <= s1_pos_r.frame_done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_chroma_r.v, out_chroma_r.u, out_luma_r};
  assign out_tuser  = out_final_r;
  assign out_tlast  = out_done_r;

  // assertions
  `include "yuv420_alpha_overlay_assert.svh"

  `YUVOVL_ASSERT(a_fire_fills_s1, in_fire |=> s1_v_r, "accepted pixel missing in stage 1")
  `YUVOVL_ASSERT(a_go_fills_out, s1_go |=> out_v_r, "advanced pixel missing in result register")
  `YUVOVL_ASSERT(a_s1_holds, (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_luma_r) && $stable(s1_pos_r)), "stalled stage 1 changed")
  `YUVOVL_ASSERT_ALWAYS(a_ready_when_empty, !s1_v_r |-> in_tready, "empty stage 1 refuses input")

endmodule

>>> verif/tb_yuv420_alpha_overlay.sv
// ----------------------------------------------------------------------------
// tb_yuv420_alpha_overlay
// self-checking bench for the watermark blend. A clocked driver pulls pixel
// requests from a queue; a clocked monitor predicts every accepted pixel
// with its own blend model and compares each result against the oldest
// prediction. Geometry and enable are changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import yuvovl_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RAND_PIXELS = 1400;
  localparam int MAX_REPORTS = 50;
  localparam int STORE_SLOTS = MAX_WIDTH_DEF / 2;
  localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;

  // one predicted result
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic             chroma_fin;
    logic             frame_end;
  } blend_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata = '0;   // luma_in, chroma_u_in, chroma_v_in, mark_red, mark_alpha
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;       // luma_out, chroma_u_out, chroma_v_out
  logic                 out_tuser;       // chroma_final
  logic                 out_tlast;       // frame_done

  logic [39:0] pixel_q[$];
  blend_res_t  blended_q[$];
  logic        in_fire = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          idle_pct = 10;
  bit          calm = 1'b0;
  int          errors = 0;
  int          quiet_cycles = 0;

  // shadow registers and blend state
  logic [CFG_W-1:0] width_reg = RST_FRAME_WIDTH;
  logic [CFG_W-1:0] height_reg = RST_FRAME_HEIGHT;
  logic             enable_reg = 1'b0;
  logic [11:0]      pix_col = '0;
  logic [11:0]      pix_row = '0;
  chroma_t          run_chroma = '0;
  chroma_t          chroma_mem [STORE_SLOTS];

  always #6 clk = ~clk;

  yuv420_alpha_overlay u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // size in use: clamped to 2..lim, rounded down to even
  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int lim);
    int s;
    s = int'(v);
    if (s < 2) s = 2;
    if (s > lim) s = lim;
    return s & ~1;
  endfunction

  function automatic logic [PIX_W-1:0] mix_toward(input logic [PIX_W-1:0] base,
                                                  input logic [PIX_W-1:0] target,
                                                  input logic [PIX_W-1:0] a);
    int unsigned num;
    num = (255 - int'(a)) * int'(base) + int'(a) * int'(target);
    return PIX_W'(num / 255);
  endfunction

  // predict one accepted pixel and advance the raster position
  function automatic void blend_pixel(input logic [39:0] d);
    int               w;
    int               h;
    int               slot;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
    logic             last_col;
    logic             last_row;
    blend_res_t       r;
    w = clamp_size(width_reg, MAX_WIDTH_DEF);
    h = clamp_size(height_reg, MAX_HEIGHT_DEF);
    a = enable_reg ? d[39:32] : '0;
    slot = int'(pix_col[11:1]);
    // block chroma: loaded on even rows, restored from the half-line store on odd rows
    if (!pix_col[0]) begin
      if (pix_row[0]) run_chroma = chroma_mem[slot];
      else run_chroma = chroma_t'({d[23:16], d[15:8]});
    end
    luma = d[7:0];
    u = run_chroma.u;
    v = run_chroma.v;
    if (a != '0) begin
      luma = mix_toward(d[7:0], d[31:24], a);
      u = mix_toward(u, CHROMA_MID, a);
      v = mix_toward(v, CHROMA_MID, a);
    end
    run_chroma.u = u;
    run_chroma.v = v;
    if (pix_col[0] && !pix_row[0]) chroma_mem[slot] = run_chroma;
    last_col = (int'(pix_col) + 1 >= w);
    last_row = (int'(pix_row) + 1 >= h);
    r.luma = luma;
    r.u = u;
    r.v = v;
    r.chroma_fin = pix_row[0] & pix_col[0];
    r.frame_end = last_col & last_row;
    blended_q.push_back(r);
    if (last_col) begin
      pix_col = '0;
      pix_row = last_row ? '0 : pix_row + 1'b1;
    end else begin
      pix_col = pix_col + 1'b1;
    end
  endfunction

  // pixels left until the raster position is back at the frame start
  function automatic int steps_to_frame_end();
    int c;
    int r;
    int w;
    int h;
    int n;
    c = int'(pix_col);
    r = int'(pix_row);
    w = clamp_size(width_reg, MAX_WIDTH_DEF);
    h = clamp_size(height_reg, MAX_HEIGHT_DEF);
    n = 0;
    while (c != 0 || r != 0) begin
      n++;
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  function automatic int frame_pixels();
    return clamp_size(width_reg, MAX_WIDTH_DEF) * clamp_size(height_reg, MAX_HEIGHT_DEF);
  endfunction

  // random pixel, alpha weighted toward zero and full
  function automatic logic [39:0] rand_pixel();
    logic [PIX_W-1:0] a;
    case ($urandom_range(0, 7))
      0, 1: a = 8'd0;
      2: a = 8'd255;
      default: a = 8'($urandom);
    endcase
    return {a, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
  endfunction

  // geometry value, bad ones included
  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'($urandom_range(2, 9));
      3: return CFG_W'(2);
      default: return CFG_W'(2 * $urandom_range(1, 16));
    endcase
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  task automatic push_pixel(input logic [7:0] y, input logic [7:0] u, input logic [7:0] v,
                            input logic [7:0] red, input logic [7:0] a);
    pixel_q.push_back({a, red, v, u, y});
  endtask

  task automatic push_random(input int n);
    repeat (n) pixel_q.push_back(rand_pixel());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FRAME_WIDTH: width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      REG_OVERLAY_ENABLE: enable_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until every request is sent and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_q.size() != 0 || in_tvalid || blended_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // request driver with random idle bursts
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0 && !calm && $urandom_range(0, 99) < idle_pct) begin
        in_gap <= $urandom_range(0, 3);
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pixel_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure with random stall bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      out_gap <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict accepted pixels, check results, watchdog
  always @(posedge clk) begin
    blend_res_t exp_r;
    if (rst_n) begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) blend_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        if (blended_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t unexpected result expected none actual %h user %b last %b",
                     $time, out_tdata, out_tuser, out_tlast);
        end else begin
          exp_r = blended_q.pop_front();
          check_field("luma_out", exp_r.luma, out_tdata[7:0]);
          check_field("chroma_u_out", exp_r.u, out_tdata[15:8]);
          check_field("chroma_v_out", exp_r.v, out_tdata[23:16]);
          check_field("chroma_final", exp_r.chroma_fin, out_tuser);
          check_field("frame_done", exp_r.frame_end, out_tlast);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("yuv420_alpha_overlay test failed");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int n;
    int k;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner pixels in a 4x2 frame, first blended then with the overlay off
    write_reg(REG_FRAME_WIDTH, CFG_W'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    for (int pass = 0; pass < 2; pass++) begin
      write_reg(REG_OVERLAY_ENABLE, CFG_W'(pass == 0));
      push_pixel(8'd0,   8'd0,   8'd255, 8'd255, 8'd255);
      push_pixel(8'd255, 8'd17,  8'd200, 8'd0,   8'd1);
      push_pixel(8'd128, 8'd255, 8'd0,   8'd0,   8'd0);
      push_pixel(8'd255, 8'd0,   8'd0,   8'd255, 8'd128);
      // odd row: chroma inputs must be ignored
      push_pixel(8'd0,   8'd255, 8'd255, 8'd0,   8'd0);
      push_pixel(8'd1,   8'd0,   8'd0,   8'd255, 8'd255);
      push_pixel(8'd254, 8'd99,  8'd1,   8'd128, 8'd1);
      push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
      wait_idle();
    end

    // bad geometry clamps to the smallest frame
    write_reg(REG_OVERLAY_ENABLE, CFG_W'(1));
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
    push_random(frame_pixels());
    wait_idle();

    // a 32-pixel line writes every store entry the random frames reach,
    // then a tall narrow frame
    write_reg(REG_FRAME_WIDTH, CFG_W'(32));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    push_random(frame_pixels());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(2));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(256));
    push_random(frame_pixels());
    wait_idle();

    // random phases of whole frames, some with geometry changed mid-frame
    n = 0;
    while (n < RAND_PIXELS) begin
      if (n >= RAND_PIXELS - 250) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      write_reg(REG_FRAME_WIDTH, pick_size());
      write_reg(REG_FRAME_HEIGHT, pick_size());
      write_reg(REG_OVERLAY_ENABLE, CFG_W'($urandom_range(0, 3) != 0));
      k = frame_pixels() * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, frame_pixels() - 1);
        if (k > RAND_PIXELS - n) k = RAND_PIXELS - n;
        push_random(k);
        n += k;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, pick_size());
        write_reg(REG_FRAME_HEIGHT, pick_size());
        k = steps_to_frame_end();
      end
      if (n + k > RAND_PIXELS) k = RAND_PIXELS - n;
      push_random(k);
      n += k;
      wait_idle();
    end

    calm = 1'b1;
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("yuv420_alpha_overlay test passed");
    else $display("yuv420_alpha_overlay test failed");
    $finish;
  end

endmodule
